/* rtl/kdcc_pkg.sv */
// ----------------------------------------------------------------------------
// kdcc_pkg: shared types and constants of the knob change detector
// Beat payloads, request codes, control codes and the fixed knob table.
// ----------------------------------------------------------------------------
`default_nettype none

package kdcc_pkg;

    // Number of knobs with a stored value.
    localparam int NUM_KNOBS = 32;
    localparam int KNOB_IDX_W = 5;
    localparam int VAL_W = 10;

    // Converter rail values.
    localparam logic [VAL_W-1:0] RAIL_LOW = 10'd0;
    localparam logic [VAL_W-1:0] RAIL_HIGH = 10'd1023;

    // Register reset values.
    localparam logic [VAL_W-1:0] CHANGE_TH_RST = 10'd8;
    localparam logic [VAL_W-1:0] TARGET_TH_RST = 10'd25;

    // Register indexes on the configuration port.
    localparam logic REG_CHANGE_TH = 1'b0;
    localparam logic REG_TARGET_TH = 1'b1;

    // Request type codes.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_PRELOAD = 2'd1;
    localparam logic [1:0] REQ_BUTTON = 2'd2;

    // Control codes with special handling.
    localparam logic [4:0] CODE_LFO_TARGET = 5'd8;
    localparam logic [4:0] CODE_PARA = 5'd19;
    localparam logic [4:0] CODE_NONE = 5'd31;

    localparam logic [1:0] CHAN_PARA = 2'd1;
    localparam logic [6:0] CC_MAX = 7'd127;
    localparam logic [6:0] CC_MIN = 7'd0;

    // One request beat.
    typedef struct packed {
        logic [1:0]            req_type;
        logic [KNOB_IDX_W-1:0] knob_index;
        logic [VAL_W-1:0]      sample_value;
        logic                  button_level;
    } t_req_item;

    // One control-change beat.
    typedef struct packed {
        logic [1:0] midi_channel;
        logic [4:0] control_code;
        logic [6:0] control_value;
        logic       led_level;
    } t_cc_item;

    // Channel of each knob in panel order.
    function automatic logic [1:0] knob_chan(input logic [KNOB_IDX_W-1:0] ix);
        logic [1:0] ch;
        case (ix)
            5'd4, 5'd5, 5'd6, 5'd7,
            5'd21, 5'd22, 5'd23, 5'd24: ch = 2'd2;
            5'd8, 5'd9, 5'd10, 5'd11:   ch = 2'd3;
            default:                    ch = 2'd1;
        endcase
        return ch;
    endfunction

    // Dense control code of each knob; the last knob has no entry.
    function automatic logic [4:0] knob_code(input logic [KNOB_IDX_W-1:0] ix);
        logic [4:0] cd;
        case (ix)
            5'd0:  cd = 5'd0;
            5'd1:  cd = 5'd1;
            5'd2:  cd = 5'd2;
            5'd3:  cd = 5'd3;
            5'd4:  cd = 5'd2;
            5'd5:  cd = 5'd0;
            5'd6:  cd = 5'd3;
            5'd7:  cd = 5'd1;
            5'd8:  cd = 5'd2;
            5'd9:  cd = 5'd0;
            5'd10: cd = 5'd1;
            5'd11: cd = 5'd3;
            5'd12: cd = 5'd4;
            5'd13: cd = 5'd5;
            5'd14: cd = 5'd6;
            5'd15: cd = 5'd7;
            5'd16: cd = CODE_LFO_TARGET;
            5'd17: cd = 5'd9;
            5'd18: cd = 5'd10;
            5'd19: cd = 5'd11;
            5'd20: cd = 5'd12;
            5'd21: cd = CODE_LFO_TARGET;
            5'd22: cd = 5'd12;
            5'd23: cd = 5'd11;
            5'd24: cd = 5'd9;
            5'd25: cd = 5'd13;
            5'd26: cd = 5'd14;
            5'd27: cd = 5'd15;
            5'd28: cd = 5'd16;
            5'd29: cd = 5'd17;
            5'd30: cd = 5'd18;
            default: cd = CODE_NONE;
        endcase
        return cd;
    endfunction

endpackage

`default_nettype wire

/* rtl/knob_deadband_to_control_change_unit.sv */
// ----------------------------------------------------------------------------
// knob_deadband_to_control_change_unit: knob deadband and para button to CC
// Each request beat is registered, evaluated against the stored knob value
// or button level, and any control change lands in a result register. A
// new request beat is taken every cycle while results drain; a request
// passes through the input register and then the result register, around
// the combinational compare, the constant scaling and the knob table
// lookup. Knob values are undefined until preloaded; sampling a knob that
// was never preloaded gives an unspecified result. The two deadbands are
// written through the APB port at 0x0 and 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_deadband_to_control_change_unit
    import kdcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_req_item   i_req,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_cc_item         o_cc,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [VAL_W-1:0]  r_change_th;
    logic [VAL_W-1:0]  r_target_th;

    logic              r_in_vld;
    t_req_item         r_in;
    logic              r_out_vld;
    t_cc_item          r_out;

    logic [VAL_W-1:0]  r_knob [NUM_KNOBS];
    logic              r_btn;
    logic              r_para;

    logic              s_adv;
    logic              s_in_range;
    logic [VAL_W-1:0]  s_prev;
    logic [VAL_W-1:0]  s_diff;
    logic [4:0]        s_code;
    logic              s_target;
    logic              s_hit;
    logic              s_pass;
    logic [16:0]       s_y127;
    logic [10:0]       s_rem127;
    logic [6:0]        s_q127;
    logic [12:0]       s_y8;
    logic [10:0]       s_rem8;
    logic [3:0]        s_q8;
    logic [3:0]        s_tval;
    logic              s_edge;
    logic              s_store;
    logic              s_emit;
    logic              n_para;
    logic              n_btn;
    t_cc_item          n_out;

    // Configuration port: always ready, writes in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET_TH) ? {22'd0, r_target_th}
                                                : {22'd0, r_change_th};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change_th <= CHANGE_TH_RST;
            r_target_th <= TARGET_TH_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_TARGET_TH) begin
                r_target_th <= pwdata[VAL_W-1:0];
            end else begin
                r_change_th <= pwdata[VAL_W-1:0];
            end
        end
    end

    // The input register moves on when the result register is free or drains.
    assign s_adv = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_req;
        end
    end

    // Deadband compare against the stored knob value.
    assign s_in_range = {1'b0, r_in.knob_index} < 6'(NUM_KNOBS);
    assign s_prev = r_knob[r_in.knob_index];
    assign s_diff = (r_in.sample_value >= s_prev) ? (r_in.sample_value - s_prev)
                                                  : (s_prev - r_in.sample_value);
    assign s_code = knob_code(r_in.knob_index);
    assign s_target = (s_code == CODE_LFO_TARGET);
    assign s_hit = (s_diff > r_change_th)
                || (r_in.sample_value == RAIL_LOW && s_prev != RAIL_LOW)
                || (r_in.sample_value == RAIL_HIGH && s_prev != RAIL_HIGH);
    assign s_pass = s_hit && (!s_target || s_diff > r_target_th);

    // Scaling by 127/1023: 1023 = 1024 - 1, so the quotient is the top bits
    // plus one correction when the remainder reaches 1023.
    assign s_y127 = ({7'd0, r_in.sample_value} << 7) - {7'd0, r_in.sample_value};
    assign s_rem127 = {1'b0, s_y127[9:0]} + {4'd0, s_y127[16:10]};
    assign s_q127 = s_y127[16:10] + {6'd0, (s_rem127 >= {1'b0, RAIL_HIGH})};

    // Target knobs: 8 - v*8/1023, with zero raised to one.
    assign s_y8 = {r_in.sample_value, 3'd0};
    assign s_rem8 = {1'b0, s_y8[9:0]} + {8'd0, s_y8[12:10]};
    assign s_q8 = {1'b0, s_y8[12:10]} + {3'd0, (s_rem8 >= {1'b0, RAIL_HIGH})};
    assign s_tval = (s_q8 == 4'd8) ? 4'd1 : (4'd8 - s_q8);

    // Request decode: knob store, button edge and result assembly.
    always_comb begin
        s_store = 1'b0;
        s_emit = 1'b0;
        s_edge = 1'b0;
        n_para = r_para;
        n_btn = r_btn;
        n_out.midi_channel = knob_chan(r_in.knob_index);
        n_out.control_code = s_code;
        n_out.control_value = s_target ? {3'd0, s_tval} : s_q127;
        n_out.led_level = !r_para;
        unique case (r_in.req_type)
            REQ_PRELOAD: begin
                s_store = s_in_range;
            end
            REQ_SAMPLE: begin
                s_store = s_in_range && s_pass;
                s_emit = s_store && (s_code != CODE_NONE);
            end
            REQ_BUTTON: begin
                s_edge = !r_in.button_level && r_btn;
                n_btn = r_in.button_level;
                n_para = r_para ^ s_edge;
                s_emit = s_edge;
                n_out.midi_channel = CHAN_PARA;
                n_out.control_code = CODE_PARA;
                n_out.control_value = n_para ? CC_MAX : CC_MIN;
                n_out.led_level = !n_para;
            end
            default: begin
                s_store = 1'b0;
            end
        endcase
    end

    // Knob value store, written as the request beat retires.
    always_ff @(posedge i_clk) begin
        if (s_adv && s_store) begin
            r_knob[r_in.knob_index] <= r_in.sample_value;
        end
    end

    // Button level and para mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn <= 1'b0;
            r_para <= 1'b0;
        end else if (s_adv) begin
            r_btn <= n_btn;
            r_para <= n_para;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_adv) begin
            r_out_vld <= s_emit;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && s_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_cc = r_out;

    // An empty input register always takes a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_in_ready)
        else $error("input register empty but not ready");

    // Para mode only changes when a button beat retires.
    a_para_on_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_para != $past(r_para)) |-> $past(s_adv && r_in.req_type == REQ_BUTTON))
        else $error("para mode changed without a button beat");

    // A para result carries channel 1 and a value that matches the LED.
    a_para_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cc.control_code == CODE_PARA) |->
            (o_cc.midi_channel == CHAN_PARA)
            && ((o_cc.control_value == CC_MAX) == !o_cc.led_level))
        else $error("malformed para mode result");

    // Target knob values stay within one to eight.
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cc.control_code == CODE_LFO_TARGET) |->
            (o_cc.control_value >= 7'd1 && o_cc.control_value <= 7'd8))
        else $error("target knob value out of range");

    // A beat that produces a result is never dropped while the slot is held.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !s_adv)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* tb/tb_knob_deadband_to_control_change_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_knob_deadband_to_control_change_unit: knob deadband and para button test
// Drives request beats through the valid/ready channel and writes both
// deadband registers over APB while the block is idle. A local predictor
// keeps its own copy of the knob values, button level, para mode and
// thresholds. It queues the control change that each accepted request should
// cause, and a checker compares every result beat with the oldest entry.
// ----------------------------------------------------------------------------

module tb_knob_deadband_to_control_change_unit;
    import kdcc_pkg::*;

    // The request code that the block must ignore.
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    // Number of steps that a target knob spans.
    localparam int TARGET_STEPS = 8;
    // Cycles from the last request to a quiet pipeline.
    localparam int PIPE_CYCLES = 4;

    // Clock, reset and the channels of the block.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_req_item   req_beat = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_cc_item    cc_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idle rates in percent, and the length of a forced receiver hold-off.
    int unsigned tx_idle_pct = 16;
    int unsigned rx_idle_pct = 70;
    int unsigned rx_hold_cycles = 0;
    int unsigned err_count = 0;

    // Predictor state: knob values, button level, para mode, thresholds.
    logic [9:0] knob_mem [32];
    bit         knob_loaded [32];
    logic       btn_last = 1'b0;
    logic       para_on = 1'b0;
    logic [9:0] chg_th = CHANGE_TH_RST;
    logic [9:0] tgt_th = TARGET_TH_RST;
    t_cc_item   cc_expect_q [$];

    // Panel table: channel and dense control code of each knob.
    bit [1:0] knob_chan_tbl [32] = '{
        1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1, 1
    };
    bit [4:0] knob_code_tbl [32] = '{
        0, 1, 2, 3, 2, 0, 3, 1, 2, 0, 1, 3, 4, 5, 6, 7,
        CODE_LFO_TARGET, 9, 10, 11, 12, CODE_LFO_TARGET, 12, 11, 9, 13, 14, 15, 16,
        17, 18, CODE_NONE
    };

    knob_deadband_to_control_change_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req       (req_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_cc        (cc_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("** knob_deadband_to_control_change_unit: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Expected control change of one accepted request, if it causes one.
    function automatic void knob_cc_predict(input t_req_item it);
        int unsigned v;
        int unsigned prev;
        int unsigned diff;
        int unsigned scaled;
        bit          moved;
        logic [4:0]  code;
        t_cc_item    cc;
        v = 32'(it.sample_value);
        case (it.req_type)
            REQ_PRELOAD: begin
                knob_mem[it.knob_index] = it.sample_value;
                knob_loaded[it.knob_index] = 1'b1;
            end
            REQ_BUTTON: begin
                // A press is a falling edge of the active-low pin.
                if (!it.button_level && btn_last) begin
                    para_on = ~para_on;
                    cc.midi_channel = CHAN_PARA;
                    cc.control_code = CODE_PARA;
                    cc.control_value = para_on ? CC_MAX : CC_MIN;
                    cc.led_level = ~para_on;
                    cc_expect_q.push_back(cc);
                end
                btn_last = it.button_level;
            end
            REQ_SAMPLE: begin
                prev = 32'(knob_mem[it.knob_index]);
                diff = (v > prev) ? v - prev : prev - v;
                code = knob_code_tbl[it.knob_index];
                moved = diff > chg_th || (v == RAIL_LOW && prev != RAIL_LOW) ||
                        (v == RAIL_HIGH && prev != RAIL_HIGH);
                // Target knobs need the wider deadband; a rail alone is not enough.
                if (code == CODE_LFO_TARGET && diff <= tgt_th) begin
                    moved = 1'b0;
                end
                if (moved) begin
                    knob_mem[it.knob_index] = it.sample_value;
                    if (code != CODE_NONE) begin
                        if (code == CODE_LFO_TARGET) begin
                            scaled = TARGET_STEPS - (v * TARGET_STEPS) / RAIL_HIGH;
                            if (scaled == 0) begin
                                scaled = 1;
                            end
                        end else begin
                            scaled = (v * CC_MAX) / RAIL_HIGH;
                        end
                        cc.midi_channel = knob_chan_tbl[it.knob_index];
                        cc.control_code = code;
                        cc.control_value = scaled[6:0];
                        cc.led_level = ~para_on;
                        cc_expect_q.push_back(cc);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_req_item mk_req(input logic [1:0] kind, input int ix,
                                         input int val, input logic btn);
        t_req_item it;
        it.req_type = kind;
        it.knob_index = ix[4:0];
        it.sample_value = val[9:0];
        it.button_level = btn;
        return it;
    endfunction

    // Random request, mostly samples, half of them near the deadband edge or at a rail.
    function automatic t_req_item pick_req();
        t_req_item it;
        int        r;
        int        th;
        int        nv;
        r = $urandom_range(99);
        it.knob_index = 5'($urandom_range(31));
        it.sample_value = 10'($urandom_range(1023));
        it.button_level = 1'($urandom_range(1));
        if (r < 10) begin
            it.req_type = REQ_PRELOAD;
        end else if (r < 24) begin
            it.req_type = REQ_BUTTON;
        end else if (r < 27) begin
            it.req_type = REQ_RESERVED;
        end else begin
            it.req_type = REQ_SAMPLE;
            case ($urandom_range(3))
                0: begin
                    th = (knob_code_tbl[it.knob_index] == CODE_LFO_TARGET) ?
                         int'(tgt_th) : int'(chg_th);
                    th = th + int'($urandom_range(2)) - 1;
                    nv = $urandom_range(1) ? int'(knob_mem[it.knob_index]) + th :
                                             int'(knob_mem[it.knob_index]) - th;
                    if (nv < 0) begin
                        nv = 0;
                    end else if (nv > 1023) begin
                        nv = 1023;
                    end
                    it.sample_value = nv[9:0];
                end
                1: it.sample_value = $urandom_range(1) ? RAIL_HIGH : RAIL_LOW;
                default: begin
                end
            endcase
        end
        return it;
    endfunction

    // Offers one request beat and returns at the edge that accepts it.
    task automatic send_req(input t_req_item it);
        int unsigned gap;
        bit          taken;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_beat <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        knob_cc_predict(it);
    endtask

    // Stops offering and waits for every expected beat plus the pipeline.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (cc_expect_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // APB write with random bits above the 10-bit register.
    task automatic cfg_write(input logic idx, input logic [9:0] val);
        logic [31:0] upper;
        upper = $urandom();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {upper[31:10], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_CHANGE_TH) begin
            chg_th = val;
        end else begin
            tgt_th = val;
        end
        @(posedge clk);
    endtask

    // APB read, compared with the value the predictor holds.
    task automatic cfg_check(input logic idx);
        logic [31:0] got;
        logic [9:0]  want;
        want = (idx == REG_CHANGE_TH) ? chg_th : tgt_th;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[9:0] !== want) begin
            report_mismatch($sformatf("register %0d read %0d, want %0d", idx, got[9:0], want));
        end
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [9:0] chg, input logic [9:0] tgt);
        wait_drained();
        cfg_write(REG_CHANGE_TH, chg);
        cfg_write(REG_TARGET_TH, tgt);
        cfg_check(REG_CHANGE_TH);
        cfg_check(REG_TARGET_TH);
    endtask

    // Random requests; a knob is always preloaded before its first sample.
    task automatic run_random_items(input int count);
        t_req_item it;
        t_req_item pre;
        repeat (count) begin
            it = pick_req();
            if (it.req_type == REQ_SAMPLE && !knob_loaded[it.knob_index]) begin
                pre = mk_req(REQ_PRELOAD, int'(it.knob_index), int'($urandom_range(1023)),
                             1'($urandom_range(1)));
                send_req(pre);
            end
            send_req(it);
        end
    endtask

    task automatic test_reset_values();
        cfg_check(REG_CHANGE_TH);
        cfg_check(REG_TARGET_TH);
    endtask

    task automatic test_directed();
        // Ordinary knob: just past and exactly at the deadband.
        send_req(mk_req(REQ_PRELOAD, 0, 500, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 0, 509, 1'b0));
        send_req(mk_req(REQ_SAMPLE, 0, 517, 1'b1));
        // Rails inside the deadband still count as a change, once.
        send_req(mk_req(REQ_PRELOAD, 1, 5, 1'b0));
        send_req(mk_req(REQ_SAMPLE, 1, 0, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 1, 0, 1'b0));
        send_req(mk_req(REQ_PRELOAD, 2, 1020, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 2, 1023, 1'b0));
        send_req(mk_req(REQ_SAMPLE, 2, 1023, 1'b1));
        // Target knobs: wider deadband, no rail rule, inverted scale.
        send_req(mk_req(REQ_PRELOAD, 16, 500, 1'b0));
        send_req(mk_req(REQ_SAMPLE, 16, 525, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 16, 526, 1'b0));
        send_req(mk_req(REQ_PRELOAD, 21, 1010, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 21, 1023, 1'b0));
        send_req(mk_req(REQ_SAMPLE, 21, 0, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 21, 1023, 1'b0));
        // The knob without a table entry stores but stays silent.
        send_req(mk_req(REQ_PRELOAD, 31, 100, 1'b1));
        send_req(mk_req(REQ_SAMPLE, 31, 900, 1'b0));
        // Para button: press on, hold, release, press off.
        send_req(mk_req(REQ_BUTTON, 7, 300, 1'b1));
        send_req(mk_req(REQ_BUTTON, 7, 300, 1'b0));
        send_req(mk_req(REQ_BUTTON, 30, 1023, 1'b0));
        send_req(mk_req(REQ_BUTTON, 30, 0, 1'b1));
        send_req(mk_req(REQ_BUTTON, 12, 682, 1'b0));
        // Reserved request type is ignored.
        send_req(mk_req(REQ_RESERVED, 5, 1023, 1'b1));
    endtask

    task automatic test_threshold_extremes();
        set_thresholds(10'd0, 10'd0);
        run_random_items(40);
        set_thresholds(10'd1023, 10'd1023);
        run_random_items(40);
    endtask

    task automatic test_random_traffic();
        // Receiver mostly idle, then sender mostly idle, then neither.
        tx_idle_pct = 16;
        rx_idle_pct = 70;
        set_thresholds(10'($urandom_range(1, 60)), 10'($urandom_range(1, 120)));
        run_random_items(120);
        tx_idle_pct = 70;
        rx_idle_pct = 16;
        set_thresholds(10'($urandom_range(1023)), 10'($urandom_range(1023)));
        run_random_items(120);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_thresholds(CHANGE_TH_RST, TARGET_TH_RST);
        run_random_items(120);
    endtask

    task automatic test_output_backpressure();
        int i;
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles = 300;
        // Rail to rail on one knob: every sample beat yields a result.
        send_req(mk_req(REQ_PRELOAD, 3, 0, 1'b0));
        for (i = 0; i < 40; i++) begin
            send_req(mk_req(REQ_SAMPLE, 3, (i % 2 == 0) ? 1023 : 0, i[0]));
        end
    endtask

    // Receiver ready: random idling, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: each beat taken at the next edge is checked here.
    always @(negedge clk) begin : cc_check
        t_cc_item want;
        if (rst_n && out_valid && out_ready) begin
            if (cc_expect_q.size() == 0) begin
                report_mismatch($sformatf("control change ch=%0d code=%0d val=%0d with none due",
                                          cc_beat.midi_channel, cc_beat.control_code,
                                          cc_beat.control_value));
            end else begin
                want = cc_expect_q.pop_front();
                if (cc_beat.midi_channel !== want.midi_channel ||
                    cc_beat.control_code !== want.control_code ||
                    cc_beat.control_value !== want.control_value ||
                    cc_beat.led_level !== want.led_level) begin
                    report_mismatch($sformatf(
                        "got ch=%0d code=%0d val=%0d led=%0d, want ch=%0d code=%0d val=%0d led=%0d",
                        cc_beat.midi_channel, cc_beat.control_code, cc_beat.control_value,
                        cc_beat.led_level, want.midi_channel, want.control_code,
                        want.control_value, want.led_level));
                end
            end
        end
    end

    // Test sequence.
    initial begin
        foreach (knob_mem[i]) begin
            knob_mem[i] = '0;
            knob_loaded[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_threshold_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();
        repeat (2 * PIPE_CYCLES) @(posedge clk);
        if (cc_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d control changes never arrived", cc_expect_q.size()));
        end
        if (err_count == 0) begin
            $display("** knob_deadband_to_control_change_unit: PASSED **");
        end else begin
            $display("** knob_deadband_to_control_change_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/kdcc_pkg.sv
rtl/knob_deadband_to_control_change_unit.sv
tb/tb_knob_deadband_to_control_change_unit.sv
